>>> rtl/core/med_pkg.sv
// ----------------------------------------------------------------------------
// med_pkg
// Shared types of the macro escape decoder: result kinds, one result
// and the group of results that one text byte can cause.
// ----------------------------------------------------------------------------
package med_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_TYPE  = 2'd0,
    KIND_PAUSE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  // most results that one text byte can cause
  localparam int unsigned RunSlots   = 3;
  localparam int unsigned QueueDepth = 2;

  // one result
  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
  } res_t;

  // results of one text byte, slot 0 first
  typedef struct packed {
    logic [1:0]                count;
    res_t [RunSlots-1:0]       slot;
  } run_t;

endpackage

>>> rtl/core/med_front.sv
// ----------------------------------------------------------------------------
// med_front
// Escape parser. Takes one text byte per cycle while fire_i is high, updates the parse state
// and hands the results that byte causes to the queue as one group.
// ----------------------------------------------------------------------------
module med_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      text_char_i,
  input  logic            final_char_i,
  output logic            push_o,
  output med_pkg::run_t   run_o
);

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChPause     = 8'h73;
  localparam logic [7:0] ChSlash     = 8'h2F;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_ESC,
    MODE_HEX1,
    MODE_PAUSE,
    MODE_SKIP
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [7:0]  held_q, held_d;
  logic [31:0] cnt_q, cnt_d;
  logic        done_q, done_d;

  // append one result to a group
  function automatic med_pkg::run_t add_res(med_pkg::run_t r_in, med_pkg::kind_e kind,
                                            logic [31:0] value);
    med_pkg::run_t r;
    r = r_in;
    r.slot[r.count].kind  = kind;
    r.slot[r.count].value = value;
    r.count = r.count + 2'd1;
    return r;
  endfunction

  // end of text: what is pending, then the finish marker
  function automatic med_pkg::run_t flush(med_pkg::run_t r_in, mode_e m, logic [7:0] held,
                                          logic [31:0] cnt);
    med_pkg::run_t r;
    r = r_in;
    case (m)
      MODE_ESC: begin
        r = add_res(r, med_pkg::KIND_TYPE, {24'd0, ChBackslash});
      end
      MODE_HEX1: begin
        r = add_res(r, med_pkg::KIND_TYPE, {24'd0, ChBackslash});
        r = add_res(r, med_pkg::KIND_TYPE, {24'd0, held});
      end
      MODE_PAUSE: begin
        r = add_res(r, med_pkg::KIND_PAUSE, cnt);
      end
      default: ;
    endcase
    r = add_res(r, med_pkg::KIND_DONE, 32'd0);
    return r;
  endfunction

  // hex digit: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h = {1'b1, c[3:0] + 4'd9};
    end
    return h;
  endfunction

  logic [4:0]  h1, h2;
  logic [7:0]  hex_byte;
  logic [35:0] cnt_mul;
  logic [31:0] cnt_next;
  logic        is_digit;

  // hex byte from the held character and this one
  assign h1 = hex_val(held_q);
  assign h2 = hex_val(text_char_i);
  always_comb begin
    hex_byte = 8'd0;
    if (h1[4]) begin
      hex_byte = h2[4] ? {h1[3:0], h2[3:0]} : {4'd0, h1[3:0]};
    end
  end

  // decimal step of the pause count, saturating
  assign is_digit = (text_char_i >= 8'h30) && (text_char_i <= 8'h39);
  assign cnt_mul  = {1'b0, cnt_q, 3'd0} + {3'd0, cnt_q, 1'b0} + {32'd0, text_char_i[3:0]};
  assign cnt_next = (cnt_mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : cnt_mul[31:0];

  // parse step
  always_comb begin
    logic fin;
    fin    = final_char_i;
    run_o  = '0;
    mode_d = mode_q;
    held_d = held_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    if (mode_q == MODE_SKIP) begin
      if (fin) begin
        mode_d = MODE_NORMAL;
        held_d = 8'd0;
        cnt_d  = 32'd0;
        done_d = 1'b0;
      end
    end else if (text_char_i == 8'd0) begin
      run_o  = flush(run_o, mode_q, held_q, cnt_q);
      mode_d = fin ? MODE_NORMAL : MODE_SKIP;
      held_d = 8'd0;
      cnt_d  = 32'd0;
      done_d = 1'b0;
    end else begin
      unique case (mode_q)
        MODE_ESC: begin
          if (text_char_i == ChBackslash) begin
            run_o  = add_res(run_o, med_pkg::KIND_TYPE, {24'd0, ChBackslash});
            mode_d = MODE_NORMAL;
          end else if (text_char_i == ChPause) begin
            mode_d = MODE_PAUSE;
            cnt_d  = 32'd0;
            done_d = 1'b0;
          end else begin
            held_d = text_char_i;
            mode_d = MODE_HEX1;
          end
        end
        MODE_HEX1: begin
          mode_d = MODE_NORMAL;
          held_d = 8'd0;
          if (hex_byte == 8'd0) begin
            run_o  = add_res(run_o, med_pkg::KIND_DONE, 32'd0);
            cnt_d  = 32'd0;
            done_d = 1'b0;
            mode_d = fin ? MODE_NORMAL : MODE_SKIP;
            fin    = 1'b0;
          end else begin
            run_o = add_res(run_o, med_pkg::KIND_TYPE, {24'd0, hex_byte});
          end
        end
        MODE_PAUSE: begin
          if (text_char_i == ChSlash) begin
            run_o  = add_res(run_o, med_pkg::KIND_PAUSE, cnt_q);
            mode_d = MODE_NORMAL;
            done_d = 1'b0;
          end else if (!done_q) begin
            if (is_digit) begin
              cnt_d = cnt_next;
            end else begin
              done_d = 1'b1;
            end
          end
        end
        default: begin
          if (text_char_i == ChBackslash) begin
            mode_d = MODE_ESC;
          end else begin
            run_o = add_res(run_o, med_pkg::KIND_TYPE, {24'd0, text_char_i});
          end
        end
      endcase
      // end of text after this byte
      if (fin) begin
        run_o  = flush(run_o, mode_d, held_d, cnt_d);
        mode_d = MODE_NORMAL;
        held_d = 8'd0;
        cnt_d  = 32'd0;
        done_d = 1'b0;
      end
    end
  end

  assign push_o = fire_i && (run_o.count != 2'd0);

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      held_q <= 8'd0;
      cnt_q  <= 32'd0;
      done_q <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // skipped text gives no results
  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SKIP) |-> !push_o)
    else $error("result pushed while skipping");

  // a zero byte outside skip mode always ends with the finish marker
  a_zero_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && mode_q != MODE_SKIP && text_char_i == 8'd0) |->
      (push_o && run_o.slot[run_o.count - 2'd1].kind == med_pkg::KIND_DONE))
    else $error("zero byte without finish marker");

endmodule

>>> rtl/core/med_queue.sv
// ----------------------------------------------------------------------------
// med_queue
// Short queue of result groups between the parser and the output side.
// ----------------------------------------------------------------------------
module med_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  med_pkg::run_t   push_data_i,
  input  logic            pop_i,
  output med_pkg::run_t   head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned Depth  = med_pkg::QueueDepth;
  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  med_pkg::run_t         mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0]     count_q;

  assign empty_o = (count_q == CountW'(0));
  assign full_o  = (count_q == CountW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CountW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CountW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

>>> rtl/core/med_back.sv
// ----------------------------------------------------------------------------
// med_back
// Output side. Walks the head group of the queue one result per cycle into the output
// register while out_stall_i allows it and marks the last result of each group.
// ----------------------------------------------------------------------------
module med_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  med_pkg::run_t   head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      kind_o,
  output logic [31:0]     value_o,
  output logic            run_end_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic       load;
  logic       last;

  // output register may take a new word
  assign load  = !valid_q || !out_stall_i;
  assign last  = (idx_q == head_i.count - 2'd1);
  assign pop_o = load && !empty_i && last;

  assign out_valid_o = valid_q;

  // result walk and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      kind_o    <= head_i.slot[idx_q].kind;
      value_o   <= head_i.slot[idx_q].value;
      run_end_o <= last;
    end
  end

  // walk stays inside the head group
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (idx_q < head_i.count))
    else $error("result index beyond group");

  // walk restarts at each new group
  a_idx_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 2'd0))
    else $error("result index not cleared after pop");

endmodule

>>> rtl/core/macro_escape_decoder.sv
// ----------------------------------------------------------------------------
// macro_escape_decoder
// Turns macro text into typed characters, pauses and a finish marker.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    text_char_i, final_char_i
//   output    out        out_valid_o / out_stall_i  kind_o, value_o, run_end_o
//
// One text word per cycle enters the parser while in_stall_o is low; its results
// are written into the group queue and from there into the output register.
// The output side sends one result word per cycle while out_stall_i is low,
// so a byte with two or three results holds the output for one word per result; the two-group queue
// absorbs that and in_stall_o rises only while the queue is full.
// Reset returns the parser to normal text and empties the queue.
// ----------------------------------------------------------------------------
module macro_escape_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_char_i,
  input  logic        final_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] value_o,
  output logic        run_end_o
);

  logic          fire;
  logic          push;
  logic          pop;
  logic          empty;
  logic          full;
  med_pkg::run_t run;
  med_pkg::run_t head;

  // input word accepted
  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  // parser
  med_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .text_char_i  (text_char_i),
    .final_char_i (final_char_i),
    .push_o       (push),
    .run_o        (run)
  );

  // group queue
  med_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (run),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  // output side
  med_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .run_end_o   (run_end_o)
  );

endmodule
